[hw/rtl/sac_pkg.sv]
// Shared constants, types and the class palette for the segmentation argmax colorizer.
package sac_pkg;

  // Memory depth and the fixed field widths
  localparam int MAX_PIXELS      = 524288;
  localparam int PIXEL_W         = $clog2(MAX_PIXELS);
  localparam int LEN_W           = 20;
  localparam int CLASS_W         = 5;
  localparam int COLOR_W         = 8;
  localparam int PALETTE_SIZE    = 19;
  localparam int NUM_CLASSES_DEF = 19;
  localparam int SCORE_BITS_DEF  = 16;

  typedef logic [PIXEL_W-1:0] pixel_t;
  typedef logic [CLASS_W-1:0] class_t;
  typedef logic [LEN_W-1:0]   len_t;
  typedef logic [COLOR_W-1:0] color_t;

  // Position of one accepted score beat
  typedef struct packed {
    pixel_t pixel;
    class_t plane;
    logic   last;
  } item_tag_t;

  // Winner of one pixel, handed to the output stage
  typedef struct packed {
    class_t cls;
    pixel_t pixel;
    logic   last;
  } result_t;

  typedef struct packed {
    color_t r;
    color_t g;
    color_t b;
  } rgb_t;

  // Fixed class palette; classes without an entry are black
  function automatic rgb_t palette_rgb(class_t k);
    rgb_t c;
    unique case (k)
      5'd0:    c = '{8'd128, 8'd64,  8'd128};
      5'd1:    c = '{8'd128, 8'd64,  8'd128};
      5'd2:    c = '{8'd70,  8'd70,  8'd70};
      5'd3:    c = '{8'd102, 8'd102, 8'd156};
      5'd4:    c = '{8'd190, 8'd153, 8'd153};
      5'd5:    c = '{8'd153, 8'd153, 8'd153};
      5'd6:    c = '{8'd250, 8'd170, 8'd30};
      5'd7:    c = '{8'd220, 8'd220, 8'd0};
      5'd8:    c = '{8'd107, 8'd142, 8'd35};
      5'd9:    c = '{8'd128, 8'd64,  8'd128};
      5'd10:   c = '{8'd70,  8'd130, 8'd180};
      5'd11:   c = '{8'd220, 8'd20,  8'd60};
      5'd12:   c = '{8'd255, 8'd0,   8'd0};
      5'd13:   c = '{8'd0,   8'd0,   8'd142};
      5'd14:   c = '{8'd0,   8'd0,   8'd70};
      5'd15:   c = '{8'd0,   8'd60,  8'd100};
      5'd16:   c = '{8'd0,   8'd80,  8'd100};
      5'd17:   c = '{8'd0,   8'd0,   8'd230};
      5'd18:   c = '{8'd119, 8'd11,  8'd32};
      default: c = '{8'd0,   8'd0,   8'd0};
    endcase
    return c;
  endfunction

endpackage

[hw/rtl/sac_score_if.sv]
// Score input channel: one signed fixed-point class score per beat.
interface sac_score_if #(
  parameter int SCORE_BITS = sac_pkg::SCORE_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [SCORE_BITS-1:0] score;

  modport source (output valid, output score, input ready);
  modport sink   (input valid, input score, output ready);
endinterface

[hw/rtl/sac_pixel_if.sv]
// Pixel output channel: palette color, winning class and position per beat.
interface sac_pixel_if ();
  logic                  valid;
  logic                  ready;
  sac_pkg::color_t       red;
  sac_pkg::color_t       green;
  sac_pkg::color_t       blue;
  sac_pkg::class_t       class_index;
  sac_pkg::pixel_t       pixel_index;
  logic                  frame_last;

  modport source (output valid, output red, output green, output blue,
                  output class_index, output pixel_index, output frame_last,
                  input ready);
  modport sink   (input valid, input red, input green, input blue,
                  input class_index, input pixel_index, input frame_last,
                  output ready);
endinterface

[hw/rtl/sac_cfg_if.sv]
// Configuration write channel carrying the frame length register.
interface sac_cfg_if ();
  logic            valid;
  logic            ready;
  sac_pkg::len_t   frame_pixels;

  modport source (output valid, output frame_pixels, input ready);
  modport sink   (input valid, input frame_pixels, output ready);
endinterface

[hw/rtl/sac_sequencer.sv]
// Frame length register and the pixel / class plane counters.
module sac_sequencer #(
  parameter int NUM_CLASSES = sac_pkg::NUM_CLASSES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  sac_cfg_if.sink            cfg,
  input  logic               advance,
  output sac_pkg::item_tag_t tag
);
  import sac_pkg::*;

  localparam class_t LAST_PLANE = CLASS_W'(NUM_CLASSES - 1);

  len_t   frame_pixels;
  pixel_t pixel_pos;
  class_t plane_pos;
  len_t   plane_len;
  logic   last_pixel;

  assign cfg.ready = 1'b1;

  // Hold the raw length; clamp it into one..MAX_PIXELS on use
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_pixels <= LEN_W'(MAX_PIXELS);
    end else if (cfg.valid) begin
      frame_pixels <= cfg.frame_pixels;
    end
  end

  always_comb begin
    if (frame_pixels == '0) begin
      plane_len = LEN_W'(1);
    end else if (frame_pixels > LEN_W'(MAX_PIXELS)) begin
      plane_len = LEN_W'(MAX_PIXELS);
    end else begin
      plane_len = frame_pixels;
    end
  end

  assign last_pixel = ({1'b0, pixel_pos} + LEN_W'(1)) >= plane_len;

  assign tag = '{pixel: pixel_pos, plane: plane_pos, last: last_pixel};

  // Advance the counters once per accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_pos <= '0;
      plane_pos <= '0;
    end else if (advance) begin
      if (last_pixel) begin
        pixel_pos <= '0;
        plane_pos <= (plane_pos == LAST_PLANE) ? '0 : plane_pos + CLASS_W'(1);
      end else begin
        pixel_pos <= pixel_pos + PIXEL_W'(1);
      end
    end
  end

endmodule

[hw/rtl/sac_argmax_mem.sv]
// Per-pixel running maximum memory with read-modify-write and forwarding.
module sac_argmax_mem #(
  parameter int NUM_CLASSES = sac_pkg::NUM_CLASSES_DEF,
  parameter int SCORE_BITS  = sac_pkg::SCORE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [SCORE_BITS-1:0] in_score,
  input  sac_pkg::item_tag_t           in_tag,
  output logic                         res_valid,
  input  logic                         res_ready,
  output sac_pkg::result_t             res
);
  import sac_pkg::*;

  localparam int     ENTRY_W    = SCORE_BITS + CLASS_W;
  localparam class_t LAST_PLANE = CLASS_W'(NUM_CLASSES - 1);

  logic [ENTRY_W-1:0] mem [MAX_PIXELS];
  logic [ENTRY_W-1:0] rd_data;

  logic                         s1_valid;
  logic signed [SCORE_BITS-1:0] s1_score;
  item_tag_t                    s1_tag;

  logic               fwd_valid;
  pixel_t             fwd_addr;
  logic [ENTRY_W-1:0] fwd_data;

  logic [ENTRY_W-1:0]           cur_entry;
  logic signed [SCORE_BITS-1:0] cur_max;
  logic                         take;
  logic [ENTRY_W-1:0]           new_entry;
  logic                         s1_emit;
  logic                         s1_fire;
  logic                         in_fire;

  // Advance stage one unless its result is blocked at the output
  assign s1_emit  = s1_tag.plane == LAST_PLANE;
  assign s1_fire  = s1_valid && (!s1_emit || res_ready);
  assign in_ready = !s1_valid || s1_fire;
  assign in_fire  = in_valid && in_ready;

  // Memory: read on accept, write back when stage one retires
  always_ff @(posedge clk) begin
    if (s1_fire) begin
      mem[s1_tag.pixel] <= new_entry;
    end
    if (in_fire) begin
      rd_data <= mem[in_tag.pixel];
    end
  end

  // Forward the write made on the same edge as this beat's read
  assign cur_entry = (fwd_valid && fwd_addr == s1_tag.pixel) ? fwd_data : rd_data;
  assign cur_max   = cur_entry[ENTRY_W-1:CLASS_W];

  // First plane stores; later planes replace only on a strictly greater score
  assign take      = (s1_tag.plane == '0) || (s1_score > cur_max);
  assign new_entry = take ? {s1_score, s1_tag.plane} : cur_entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      fwd_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid  <= 1'b1;
        fwd_valid <= s1_fire;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
    end
  end

  // Capture the beat and the write that overlaps its read
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_score <= in_score;
      s1_tag   <= in_tag;
      fwd_addr <= s1_tag.pixel;
      fwd_data <= new_entry;
    end
  end

  assign res_valid = s1_valid && s1_emit;
  assign res       = '{cls: new_entry[CLASS_W-1:0], pixel: s1_tag.pixel, last: s1_tag.last};

endmodule

[hw/rtl/sac_colorize.sv]
// Output register: palette lookup of the winning class and the pixel beat.
module sac_colorize (
  input  logic             clk,
  input  logic             rst,
  input  logic             res_valid,
  output logic             res_ready,
  input  sac_pkg::result_t res,
  sac_pixel_if.source      pixels
);
  import sac_pkg::*;

  rgb_t color;

  assign color     = palette_rgb(res.cls);
  assign res_ready = !pixels.valid || pixels.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixels.valid <= 1'b0;
    end else if (res_ready) begin
      pixels.valid <= res_valid;
    end
  end

  // Load a new beat whenever the register is free or being drained
  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      pixels.red         <= color.r;
      pixels.green       <= color.g;
      pixels.blue        <= color.b;
      pixels.class_index <= res.cls;
      pixels.pixel_index <= res.pixel;
      pixels.frame_last  <= res.last;
    end
  end

endmodule

[hw/rtl/segmentation_argmax_colorize.sv]
// Top level of the segmentation argmax colorizer.
//
//   channel  | dir | payload                                        | handshake
//   scores   | in  | score (signed Q8.8)                            | valid/ready
//   pixels   | out | red, green, blue, class_index, pixel_index,    | valid/ready
//            |     | frame_last                                     |
//   cfg      | in  | frame_pixels                                   | valid/ready
//
// One score beat per cycle unless the output stalls, a rate set by the single
// read-modify-write pass through the running-maximum memory, with the previous
// write forwarded. Pixel beats pass the memory stage, then the output register.
// Reset clears the counters, the frame length (to the full frame) and the
// pipeline valids; memory contents are left as they are.
// A stalled output holds one pixel in the output register and one in the
// memory stage; scores are then refused until the output drains.
module segmentation_argmax_colorize #(
  parameter int NUM_CLASSES = sac_pkg::NUM_CLASSES_DEF,
  parameter int SCORE_BITS  = sac_pkg::SCORE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  sac_score_if.sink   scores,
  sac_pixel_if.source pixels,
  sac_cfg_if.sink     cfg
);
  import sac_pkg::*;

  item_tag_t tag;
  logic      in_ready;
  logic      res_valid;
  logic      res_ready;
  result_t   res;

  assign scores.ready = in_ready;

  sac_sequencer #(
    .NUM_CLASSES (NUM_CLASSES)
  ) u_sequencer (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .advance (scores.valid && in_ready),
    .tag     (tag)
  );

  sac_argmax_mem #(
    .NUM_CLASSES (NUM_CLASSES),
    .SCORE_BITS  (SCORE_BITS)
  ) u_argmax_mem (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (scores.valid),
    .in_ready  (in_ready),
    .in_score  (scores.score),
    .in_tag    (tag),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  sac_colorize u_colorize (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .pixels    (pixels)
  );

endmodule

[dv/sac_checker.sv]
`timescale 1ns / 1ps
// Checker for the segmentation argmax colorizer: predicts pixel beats and compares them.
module sac_checker
  import sac_pkg::*;
(
  input  logic clk,
  input  logic rst,
  sac_score_if scores,
  sac_pixel_if pixels,
  sac_cfg_if   cfg,
  output int   fail_count,
  output int   pending
);

  localparam int NUM_PLANES   = NUM_CLASSES_DEF;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    color_t red;
    color_t green;
    color_t blue;
    class_t cls;
    pixel_t pixel;
    logic   last;
  } pixel_beat_t;

  // Class colors packed as red, green, blue
  localparam logic [23:0] CLASS_COLOR [PALETTE_SIZE] = '{
    24'h804080, 24'h804080, 24'h464646, 24'h66669C, 24'hBE9999,
    24'h999999, 24'hFAAA1E, 24'hDCDC00, 24'h6B8E23, 24'h804080,
    24'h4682B4, 24'hDC143C, 24'hFF0000, 24'h00008E, 24'h000046,
    24'h003C64, 24'h005064, 24'h0000E6, 24'h770B20
  };

  function automatic logic [23:0] color_of(class_t k);
    if (k < PALETTE_SIZE) return CLASS_COLOR[k];
    return 24'h000000;
  endfunction

  len_t               frame_len;
  int                 pixel_pos;
  int                 plane_pos;
  int                 errors;
  logic signed [15:0] peak_score [int];
  class_t             peak_class [int];
  pixel_beat_t        expected_q [$];

  always @(posedge clk) begin
    int                 plane_len;
    int                 addr;
    logic               last_px;
    logic signed [15:0] held;
    logic [23:0]        rgb;
    pixel_beat_t        exp_beat;
    pixel_beat_t        got_beat;
    if (rst) begin
      frame_len = len_t'(MAX_PIXELS);
      pixel_pos = 0;
      plane_pos = 0;
      errors    = 0;
      expected_q.delete();
    end else begin
      // Take a new frame length
      if (cfg.valid && cfg.ready) begin
        frame_len = cfg.frame_pixels;
      end

      // Fold an accepted score into the running maximum of its pixel
      if (scores.valid && scores.ready) begin
        plane_len = (frame_len == 0) ? 1 :
                    (frame_len > MAX_PIXELS) ? MAX_PIXELS : int'(frame_len);
        addr    = pixel_pos % MAX_PIXELS;
        last_px = (pixel_pos + 1 >= plane_len);
        held    = peak_score.exists(addr) ? peak_score[addr] : 16'sd0;
        if (plane_pos == 0) begin
          peak_score[addr] = scores.score;
          peak_class[addr] = '0;
        end else if (scores.score > held) begin
          peak_score[addr] = scores.score;
          peak_class[addr] = class_t'(plane_pos);
        end

        // Last plane: the winner of this pixel leaves as a colored beat
        if (plane_pos == NUM_PLANES - 1) begin
          exp_beat.cls   = peak_class.exists(addr) ? peak_class[addr] : '0;
          rgb            = color_of(exp_beat.cls);
          exp_beat.red   = rgb[23:16];
          exp_beat.green = rgb[15:8];
          exp_beat.blue  = rgb[7:0];
          exp_beat.pixel = pixel_t'(addr);
          exp_beat.last  = last_px;
          expected_q.push_back(exp_beat);
        end

        // Advance pixel and plane counters
        if (last_px) begin
          pixel_pos = 0;
          plane_pos = (plane_pos + 1 >= NUM_PLANES) ? 0 : plane_pos + 1;
        end else begin
          pixel_pos = pixel_pos + 1;
        end
      end

      // Compare each pixel beat with the oldest prediction
      if (pixels.valid && pixels.ready) begin
        got_beat.red   = pixels.red;
        got_beat.green = pixels.green;
        got_beat.blue  = pixels.blue;
        got_beat.cls   = pixels.class_index;
        got_beat.pixel = pixels.pixel_index;
        got_beat.last  = pixels.frame_last;
        if (expected_q.size() == 0) begin
          errors = errors + 1;
          if (errors <= REPORT_LIMIT) begin
            $display("%0t: pixel beat with nothing predicted: rgb %0d/%0d/%0d class %0d pixel %0d last %0b",
                     $time, got_beat.red, got_beat.green, got_beat.blue, got_beat.cls,
                     got_beat.pixel, got_beat.last);
          end
        end else begin
          exp_beat = expected_q.pop_front();
          if (got_beat.red !== exp_beat.red || got_beat.green !== exp_beat.green ||
              got_beat.blue !== exp_beat.blue || got_beat.cls !== exp_beat.cls ||
              got_beat.pixel !== exp_beat.pixel || got_beat.last !== exp_beat.last) begin
            errors = errors + 1;
            if (errors <= REPORT_LIMIT) begin
              $display("%0t: pixel beat mismatch: expected rgb %0d/%0d/%0d class %0d pixel %0d last %0b",
                       $time, exp_beat.red, exp_beat.green, exp_beat.blue, exp_beat.cls,
                       exp_beat.pixel, exp_beat.last);
              $display("%0t:                      got rgb %0d/%0d/%0d class %0d pixel %0d last %0b",
                       $time, got_beat.red, got_beat.green, got_beat.blue, got_beat.cls,
                       got_beat.pixel, got_beat.last);
            end
          end
        end
      end
    end
    pending    <= expected_q.size();
    fail_count <= errors;
  end

endmodule

[dv/segmentation_argmax_colorize_tb.sv]
`timescale 1ns / 1ps
// Testbench top for the segmentation argmax colorizer: stimulus, idling and verdict.
module segmentation_argmax_colorize_tb;
  import sac_pkg::*;

  localparam int NUM_PLANES    = NUM_CLASSES_DEF;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int MODE_ITEMS    = 217;
  localparam int MODE_PIXELS   = 14;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   pending;
  int   cycle_count = 0;
  int   src_idle_pct = 0;
  int   sink_idle_pct = 0;

  // Mirror of the block's position, kept to shape the stimulus
  int   eff_len = MAX_PIXELS;
  int   px_pos = 0;
  int   plane = 0;
  int   written_px = 0;
  int   pixels_sent = 0;

  always #1 clk = ~clk;

  sac_score_if score_bus ();
  sac_pixel_if pixel_bus ();
  sac_cfg_if   cfg_bus ();

  segmentation_argmax_colorize u_top (
    .clk    (clk),
    .rst    (rst),
    .scores (score_bus),
    .pixels (pixel_bus),
    .cfg    (cfg_bus)
  );

  sac_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .scores     (score_bus),
    .pixels     (pixel_bus),
    .cfg        (cfg_bus),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Stall the pixel channel at random
  initial begin
    pixel_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      pixel_bus.ready = ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("segmentation_argmax_colorize verification failed");
      $finish;
    end
  end

  // Send one score beat, idling first at random; returns at a falling edge
  task automatic send_score(input logic signed [15:0] s);
    while ($urandom_range(99) < src_idle_pct) begin
      score_bus.valid = 1'b0;
      @(negedge clk);
    end
    score_bus.valid = 1'b1;
    score_bus.score = s;
    do @(posedge clk); while (!score_bus.ready);
    @(negedge clk);
    if (plane == 0 && px_pos + 1 > written_px) written_px = px_pos + 1;
    if (plane == NUM_PLANES - 1) pixels_sent++;
    if (px_pos + 1 >= eff_len) begin
      px_pos = 0;
      plane  = (plane + 1 >= NUM_PLANES) ? 0 : plane + 1;
    end else begin
      px_pos++;
    end
  endtask

  // Hold off scores until every pixel is out and the pipeline has drained
  task automatic settle();
    score_bus.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_frame_len(input len_t raw);
    settle();
    cfg_bus.valid        = 1'b1;
    cfg_bus.frame_pixels = raw;
    do @(posedge clk); while (!cfg_bus.ready);
    @(negedge clk);
    cfg_bus.valid = 1'b0;
    eff_len = (raw == 0) ? 1 : (raw > MAX_PIXELS) ? MAX_PIXELS : int'(raw);
  endtask

  // Mix full-range scores with a narrow band that forces ties, and the extremes
  function automatic logic signed [15:0] pick_score();
    int band;
    logic signed [15:0] s;
    case ($urandom_range(9))
      0, 1, 2, 3, 4: s = 16'($urandom);
      5, 6, 7: begin
        band = int'($urandom_range(6)) - 3;
        s    = band[15:0];
      end
      8:       s = 16'sh7FFF;
      default: s = 16'sh8000;
    endcase
    return s;
  endfunction

  // Mostly short planes, sometimes zero; later planes only revisit stored pixels
  function automatic len_t pick_frame_len();
    int   roll;
    len_t raw;
    roll = $urandom_range(99);
    if (roll < 10) raw = '0;
    else if (roll < 80) raw = len_t'($urandom_range(6, 1));
    else raw = len_t'($urandom_range(12, 7));
    if (plane != 0 && ((raw == 0) ? 1 : int'(raw)) > written_px) begin
      raw = len_t'($urandom_range(written_px, 1));
    end
    return raw;
  endfunction

  initial begin
    int seg;
    int mode_items;
    int mode_start;
    score_bus.valid      = 1'b0;
    score_bus.score      = '0;
    cfg_bus.valid        = 1'b0;
    cfg_bus.frame_pixels = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: start at the full-frame reset length, then shrink mid-plane
    send_score(16'sh8000);
    send_score(16'sh7FFF);
    write_frame_len(20'hFFFFF);
    send_score(16'sh0000);
    write_frame_len(20'h00000);
    send_score(16'sh0005);
    // Pixel 0 holds the minimum; tie it, climb, then tie at the top
    send_score(16'sh8000);
    for (int k = 2; k <= 16; k++) send_score(16'(-30000 + 3000 * k));
    send_score(16'sh7FFF);
    send_score(16'sh7FFF);

    // Random frames under three idling patterns
    for (int mode = 0; mode < 3; mode++) begin
      src_idle_pct  = (mode == 0) ? 12 : (mode == 1) ? 47 : 0;
      sink_idle_pct = (mode == 0) ? 47 : (mode == 1) ? 12 : 0;
      mode_items    = 0;
      mode_start    = pixels_sent;
      while (mode_items < MODE_ITEMS || pixels_sent - mode_start < MODE_PIXELS) begin
        write_frame_len(pick_frame_len());
        if ($urandom_range(3) != 0) begin
          // run to the end of the frame
          seg = ((eff_len > px_pos) ? eff_len - px_pos : 1) +
                (NUM_PLANES - 1 - plane) * eff_len;
        end else begin
          seg = $urandom_range(40, 1);
        end
        repeat (seg) send_score(pick_score());
        mode_items += seg;
      end
    end

    // Drain and give the verdict
    score_bus.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (2 * SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("segmentation_argmax_colorize verification clean");
    end else begin
      $display("segmentation_argmax_colorize verification failed");
    end
    $finish;
  end

endmodule
